// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands for the length decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, including while reset is held.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/ild_pkg.sv -----
// ----------------------------------------------------------------------------
// ild_pkg
// Shared constants, opcode class table and types of the length decoder.
// ----------------------------------------------------------------------------
package ild_pkg;

    localparam int WINDOW_BYTES = 17;
    localparam int MAX_PREFIXES = 16;
    localparam int IDX_W        = $clog2(WINDOW_BYTES);
    localparam int LEN_W        = 5;

    // Prefix bytes
    localparam logic [7:0] PFX_SEG_ES = 8'h26;
    localparam logic [7:0] PFX_SEG_CS = 8'h2e;
    localparam logic [7:0] PFX_SEG_SS = 8'h36;
    localparam logic [7:0] PFX_SEG_DS = 8'h3e;
    localparam logic [7:0] PFX_SEG_FS = 8'h64;
    localparam logic [7:0] PFX_SEG_GS = 8'h65;
    localparam logic [7:0] PFX_OPSIZE = 8'h66;
    localparam logic [7:0] PFX_ADSIZE = 8'h67;
    localparam logic [7:0] PFX_LOCK   = 8'hf0;
    localparam logic [7:0] PFX_REPNE  = 8'hf2;
    localparam logic [7:0] PFX_REP    = 8'hf3;

    localparam logic [7:0] OPC_ESCAPE = 8'h0f;
    localparam logic [7:0] MODRM_MASK = 8'hc7;

    // Opcode classes
    localparam logic [3:0] CLS_NONE        = 4'd0;
    localparam logic [3:0] CLS_OP          = 4'd1;
    localparam logic [3:0] CLS_IMM8        = 4'd2;
    localparam logic [3:0] CLS_IMMV        = 4'd3;
    localparam logic [3:0] CLS_MOFFS       = 4'd4;
    localparam logic [3:0] CLS_IMMV_IMM8   = 4'd5;
    localparam logic [3:0] CLS_MOFFS_IMM16 = 4'd6;
    localparam logic [3:0] CLS_MRM         = 4'd7;
    localparam logic [3:0] CLS_MRM_IMM8    = 4'd8;
    localparam logic [3:0] CLS_MRM_IMMV    = 4'd9;

    localparam logic [3:0] OP_CLASS [256] = '{
        4'd7, 4'd7, 4'd7, 4'd7, 4'd2, 4'd3, 4'd1, 4'd1, 4'd7, 4'd7, 4'd7, 4'd7, 4'd2, 4'd3, 4'd1, 4'd0,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd2, 4'd3, 4'd1, 4'd1, 4'd7, 4'd7, 4'd7, 4'd7, 4'd2, 4'd3, 4'd1, 4'd1,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd2, 4'd3, 4'd0, 4'd1, 4'd7, 4'd7, 4'd7, 4'd7, 4'd2, 4'd3, 4'd0, 4'd1,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd2, 4'd3, 4'd0, 4'd1, 4'd7, 4'd7, 4'd7, 4'd7, 4'd2, 4'd3, 4'd0, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd7, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0, 4'd3, 4'd9, 4'd2, 4'd8, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd8, 4'd9, 4'd8, 4'd8, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd8, 4'd8, 4'd3, 4'd1, 4'd7, 4'd7, 4'd8, 4'd9, 4'd5, 4'd1, 4'd3, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd2, 4'd2, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd4, 4'd4, 4'd6, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd0, 4'd1, 4'd0, 4'd0, 4'd1, 4'd1, 4'd7, 4'd7, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd7, 4'd7
    };

    // Prefix scan result handed to the length calculation
    typedef struct packed {
        logic [IDX_W-1:0] pfx_cnt;
        logic             too_many;
        logic             osz;
        logic             asz;
        logic [7:0]       opcode;
        logic [7:0]       modrm;
    } scan_t;

    function automatic logic is_prefix(input logic [7:0] b);
        logic hit;
        unique case (b) inside
            PFX_SEG_ES, PFX_SEG_CS, PFX_SEG_SS, PFX_SEG_DS, PFX_SEG_FS, PFX_SEG_GS,
            PFX_OPSIZE, PFX_ADSIZE, PFX_LOCK, PFX_REPNE, PFX_REP: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ----- rtl/ild_if.sv -----
// ----------------------------------------------------------------------------
// ild_if
// Valid/ready channels of the length decoder: code window in, length out.
// ----------------------------------------------------------------------------
interface ild_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] code_low;
    logic [63:0] code_high;
    logic [7:0]  code_last;
    logic        default_wide;

    modport source (output valid, output code_low, output code_high,
                    output code_last, output default_wide, input ready);
    modport sink   (input valid, input code_low, input code_high,
                    input code_last, input default_wide, output ready);
endinterface

interface ild_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] length;

    modport source (output valid, output length, input ready);
    modport sink   (input valid, input length, output ready);
endinterface

// ----- rtl/ild_prefix_scan.sv -----
// ----------------------------------------------------------------------------
// ild_prefix_scan
// Counts leading prefix bytes, tracks size toggles, picks opcode and modrm.
// ----------------------------------------------------------------------------
module ild_prefix_scan
    import ild_pkg::*;
(
    input  logic [63:0] code_low,
    input  logic [63:0] code_high,
    input  logic [7:0]  code_last,
    input  logic        default_wide,
    output scan_t       scan
);

    logic [7:0]             win [WINDOW_BYTES];
    logic [WINDOW_BYTES-1:0] pfx;
    logic [WINDOW_BYTES-1:0] lead;
    logic [WINDOW_BYTES-1:0] is_op66;
    logic [WINDOW_BYTES-1:0] is_ad67;
    logic [IDX_W-1:0]       cnt;
    logic                   too_many;
    logic [IDX_W-1:0]       op_idx;
    logic [IDX_W-1:0]       mrm_idx;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            win[k]     = code_low[8*k +: 8];
            win[k + 8] = code_high[8*k +: 8];
        end
        win[WINDOW_BYTES-1] = code_last;

        for (int k = 0; k < WINDOW_BYTES; k++)
        begin
            pfx[k]     = is_prefix(win[k]);
            is_op66[k] = (win[k] == PFX_OPSIZE);
            is_ad67[k] = (win[k] == PFX_ADSIZE);
        end

        // lead marks the bytes that sit inside the unbroken prefix run
        lead[0] = pfx[0];
        for (int k = 1; k < WINDOW_BYTES; k++)
        begin
            lead[k] = lead[k-1] & pfx[k];
        end
    end

    assign cnt      = IDX_W'($countones(lead));
    assign too_many = (cnt >= IDX_W'(MAX_PREFIXES));
    assign op_idx   = too_many ? '0 : cnt;
    assign mrm_idx  = too_many ? '0 : cnt + IDX_W'(1);

    assign scan.pfx_cnt  = cnt;
    assign scan.too_many = too_many;
    assign scan.osz      = default_wide ^ (^(lead & is_op66));
    assign scan.asz      = default_wide ^ (^(lead & is_ad67));
    assign scan.opcode   = win[op_idx];
    assign scan.modrm    = win[mrm_idx];

endmodule

// ----- rtl/ild_length_calc.sv -----
// ----------------------------------------------------------------------------
// ild_length_calc
// Classifies the opcode and sums prefix, opcode, modrm, displacement and immediate bytes.
// ----------------------------------------------------------------------------
module ild_length_calc
    import ild_pkg::*;
(
    input  scan_t            scan,
    output logic [LEN_W-1:0] length
);

    logic [3:0] op_cls;
    logic [7:0] mrm;
    logic [1:0] mod_f;
    logic [2:0] rm_f;
    logic [2:0] mrm_len;
    logic [3:0] base;
    logic [2:0] immv_len;
    logic       decodable;

    assign op_cls   = OP_CLASS[scan.opcode];
    assign mrm      = scan.modrm & MODRM_MASK;
    assign mod_f    = mrm[7:6];
    assign rm_f     = mrm[2:0];
    assign immv_len = scan.osz ? 3'd4 : 3'd2;

    // modrm byte plus SIB and displacement
    always_comb
    begin
        if (scan.asz)
        begin
            if (mrm == 8'h05)
            begin
                mrm_len = 3'd5;
            end
            else
            begin
                case (mod_f)
                    2'd1:    mrm_len = 3'd2;
                    2'd2:    mrm_len = 3'd5;
                    default: mrm_len = 3'd1;
                endcase
                if (mod_f != 2'd3 && rm_f == 3'd4)
                begin
                    mrm_len = mrm_len + 3'd1;
                end
            end
        end
        else
        begin
            if (mrm == 8'h06)
            begin
                mrm_len = 3'd3;
            end
            else
            begin
                case (mod_f)
                    2'd1:    mrm_len = 3'd2;
                    2'd2:    mrm_len = 3'd3;
                    default: mrm_len = 3'd1;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (op_cls)
            CLS_OP:          base = 4'd1;
            CLS_IMM8:        base = 4'd2;
            CLS_IMMV:        base = scan.osz ? 4'd5 : 4'd3;
            CLS_MOFFS:       base = scan.asz ? 4'd5 : 4'd3;
            CLS_IMMV_IMM8:   base = scan.osz ? 4'd6 : 4'd4;
            CLS_MOFFS_IMM16: base = scan.asz ? 4'd7 : 4'd5;
            CLS_MRM:         base = 4'd1 + 4'(mrm_len);
            CLS_MRM_IMM8:    base = 4'd2 + 4'(mrm_len);
            CLS_MRM_IMMV:    base = 4'd1 + 4'(mrm_len) + 4'(immv_len);
            default:         base = 4'd0;
        endcase
    end

    assign decodable = !scan.too_many && (scan.opcode != OPC_ESCAPE) && (op_cls != CLS_NONE);
    assign length    = decodable ? (LEN_W'(base) + LEN_W'(scan.pfx_cnt)) : '0;

endmodule

// ----- rtl/x86_instruction_length_decoder.sv -----
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder
// Path: an accepted window beat goes through the input register, then the result register.
// Throughput: one window per cycle unless out_ch stalls; input register, decode logic, result reg.
// Reset: rst_n clears both valid flags asynchronously; data regs keep junk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module x86_instruction_length_decoder
    import ild_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ild_in_if.sink    in_ch,
    ild_out_if.source out_ch
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [63:0] code_low_reg;
    logic [63:0] code_high_reg;
    logic [7:0]  code_last_reg;
    logic        default_wide_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;

    logic  out_open;
    logic  s1_move;
    logic  in_take;
    scan_t scan;

    ild_prefix_scan u_scan (
        .code_low     (code_low_reg),
        .code_high    (code_high_reg),
        .code_last    (code_last_reg),
        .default_wide (default_wide_reg),
        .scan         (scan)
    );

    ild_length_calc u_calc (
        .scan   (scan),
        .length (length_next)
    );

    assign out_open    = !out_valid_reg || out_ch.ready;
    assign s1_move     = s1_valid_reg && out_open;
    assign in_ch.ready = !s1_valid_reg || out_open;
    assign in_take     = in_ch.valid && in_ch.ready;

    assign s1_valid_next  = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            code_low_reg     <= in_ch.code_low;
            code_high_reg    <= in_ch.code_high;
            code_last_reg    <= in_ch.code_last;
            default_wide_reg <= in_ch.default_wide;
        end
        // hold the result until the beat is taken
        if (s1_move)
        begin
            length_reg <= length_next;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.length = length_reg;

    `ASSERT_CLK(a_full_take_needs_drain, in_take && s1_valid_reg |-> s1_move,
                "window accepted over a held window that is not draining")
    `ASSERT_CLK(a_move_fills_output, s1_move |=> out_valid_reg,
                "decoded window did not land in the result register")
    `ASSERT_CLK(a_prefix_flood_zero, s1_move && scan.too_many |=> length_reg == '0,
                "prefix flood gave a nonzero length")
    `ASSERT_CLK(a_length_range, out_valid_reg |-> length_reg <= LEN_W'(26),
                "length beyond the largest encodable instruction")
    `ASSERT_CLK_ALWAYS(a_reset_clears, !rst_n |-> !out_ch.valid,
                "result valid while reset is held")

endmodule
